FILE: src/v2py_pkg.sv
// ----------------------------------------------------------------------------
// v2py_pkg
// Shared constants, types and tables for the pitch/yaw pointing pipeline.
// ----------------------------------------------------------------------------
package v2py_pkg;

  localparam int CordicStages = 20;
  localparam int PosW         = 32;
  localparam int DW           = 34;     // difference vector width
  localparam int CW           = 36;     // CORDIC x/y datapath width
  localparam int AngW         = 26;     // angle accumulator, deg Q16
  localparam int SqW          = 62;     // sum of squares width
  localparam int RootW        = 31;     // square root width
  localparam int ElevW        = 16;
  localparam int AzimW        = 17;

  localparam logic signed [AngW-1:0] Ang180  = 26'sd11796480;
  localparam logic signed [AngW-1:0] ElevLim = 26'sd23040;
  localparam logic signed [AngW-1:0] AzimLim = 26'sd46080;

  typedef enum logic [0:0] {
    CFG_EYE_HEIGHT  = 1'b0,
    CFG_CROUCH_DROP = 1'b1
  } cfg_idx_t;

  function automatic logic signed [AngW-1:0] atan_deg(input int i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        0: v = 26'sd2949120;   1: v = 26'sd1740967;   2: v = 26'sd919879;
        3: v = 26'sd466945;    4: v = 26'sd234379;    5: v = 26'sd117304;
        6: v = 26'sd58666;     7: v = 26'sd29335;     8: v = 26'sd14668;
        9: v = 26'sd7334;     10: v = 26'sd3667;     11: v = 26'sd1833;
        12: v = 26'sd917;     13: v = 26'sd458;      14: v = 26'sd229;
        15: v = 26'sd115;     16: v = 26'sd57;       17: v = 26'sd29;
        18: v = 26'sd14;      19: v = 26'sd7;        20: v = 26'sd4;
        21: v = 26'sd2;       22: v = 26'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // round half up to Q8, clamp to +-lim
  function automatic logic signed [AngW-1:0] finish(input logic signed [AngW-1:0] z,
                                                   input logic signed [AngW-1:0] lim);
    logic signed [AngW-1:0] r;
    begin
      r = (z + 26'sd128) >>> 8;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    end
  endfunction

endpackage

FILE: src/vector_to_pitch_yaw.sv
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw
// Elevation and azimuth from observer to target by pipelined CORDIC.
// ----------------------------------------------------------------------------
// Input channel in_*: one transaction carries both positions, the crouch
// flag (in_tuser) and the vertical bias. Result channel out_*: elevation,
// azimuth and the degenerate flag (out_tuser).
// Config channel cfg_*: index 0 eye height offset, 1 crouch drop; write only
// while idle. cfg_ready is always high.
// Throughput: one transaction per cycle unless the output stalls. Pipeline:
// 4 front stages (difference, magnitude/shift, squares, sum), 31 square root
// stages of one bit each, then 20 CORDIC stages and a rounding stage.
// Reset clears all valid bits and loads the register defaults.
// When out_tready is low and a result is waiting, one global enable holds the
// whole pipeline; in_tready is high whenever the output register is empty or
// being taken.
// ----------------------------------------------------------------------------
module vector_to_pitch_yaw
  import v2py_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // observer_x, observer_y, observer_z, target_x, target_y, target_z, vertical_bias
  input  logic [207:0] in_tdata,
  // crouched
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // elevation_deg, azimuth_deg (33 bits, padded to 40)
  output logic [39:0]  out_tdata,
  // degenerate
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int NS = 4 + RootW + CordicStages;  // stages before output reg

  logic [15:0] eye_r, crouch_r;
  logic        en;

  assign cfg_ready = 1'b1;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r    <= 16'd16640;
      crouch_r <= 16'd3840;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EYE_HEIGHT:  eye_r    <= cfg_data;
        CFG_CROUCH_DROP: crouch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NS:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-1:0], in_tvalid};
  end

  // stage 1: differences
  logic signed [DW-1:0] dx1_r, dy1_r, dz1_r;
  logic signed [PosW-1:0] ox, oy, oz, tx, ty, tz;
  logic signed [15:0] vb;
  assign ox = in_tdata[31:0];    assign oy = in_tdata[63:32];
  assign oz = in_tdata[95:64];   assign tx = in_tdata[127:96];
  assign ty = in_tdata[159:128]; assign tz = in_tdata[191:160];
  assign vb = in_tdata[207:192];

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= DW'(ox) - DW'(tx);
      dy1_r <= DW'(oy) - DW'(ty);
      dz1_r <= DW'(oz) - DW'(tz) + DW'({1'b0, eye_r}) + DW'(vb)
               - (in_tuser ? DW'({1'b0, crouch_r}) : DW'(0));
    end
  end

  // stage 2: azimuth start, magnitudes scaled, degenerate
  logic [DW-1:0] mx, my, mz, mm;
  logic [2:0]    sh;
  assign mx = dx1_r[DW-1] ? DW'(-dx1_r) : dx1_r;
  assign my = dy1_r[DW-1] ? DW'(-dy1_r) : dy1_r;
  assign mz = dz1_r[DW-1] ? DW'(-dz1_r) : dz1_r;
  always_comb begin
    mm = mx;
    if (my > mm) mm = my;
    if (mz > mm) mm = mz;
    if (mm[33]) sh = 3'd4;
    else if (mm[32]) sh = 3'd3;
    else if (mm[31]) sh = 3'd2;
    else if (mm[30]) sh = 3'd1;
    else sh = 3'd0;
  end

  logic signed [CW-1:0] ax2_r, ay2_r;
  logic signed [AngW-1:0] az2_r;
  logic [29:0] sx2_r, sy2_r, sz2_r;
  logic zn2_r, dg2_r, zp2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (dx1_r > 0) begin
        ax2_r <= CW'(dx1_r);
        ay2_r <= CW'(dy1_r);
        az2_r <= (dy1_r < 0) ? Ang180 : -Ang180;
      end else begin
        ax2_r <= -CW'(dx1_r);
        ay2_r <= -CW'(dy1_r);
        az2_r <= '0;
      end
      sx2_r <= 30'(mx >> sh);
      sy2_r <= 30'(my >> sh);
      sz2_r <= 30'(mz >> sh);
      zn2_r <= dz1_r[DW-1];
      zp2_r <= dz1_r > 0;
      dg2_r <= (dx1_r == 0) && (dy1_r == 0);
    end
  end

  // stage 3: squares (30x30 each)
  logic [SqW-1:0] xx3_r, yy3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  logic signed [AngW-1:0] az3_r;
  logic [29:0] sz3_r;
  logic zn3_r, dg3_r, zp3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx3_r <= SqW'(sx2_r) * SqW'(sx2_r);
      yy3_r <= SqW'(sy2_r) * SqW'(sy2_r);
      {ax3_r, ay3_r, az3_r, sz3_r, zn3_r, dg3_r, zp3_r} <=
        {ax2_r, ay2_r, az2_r, sz2_r, zn2_r, dg2_r, zp2_r};
    end
  end

  // stage 4: sum
  logic [SqW-1:0] sq4_r;
  logic signed [CW-1:0] ax4_r, ay4_r;
  logic signed [AngW-1:0] az4_r;
  logic [29:0] sz4_r;
  logic zn4_r, dg4_r, zp4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sq4_r <= xx3_r + yy3_r;
      {ax4_r, ay4_r, az4_r, sz4_r, zn4_r, dg4_r, zp4_r} <=
        {ax3_r, ay3_r, az3_r, sz3_r, zn3_r, dg3_r, zp3_r};
    end
  end

  // square root: one result bit per stage, restoring
  logic [SqW+1:0] rn_r [RootW+1];
  logic [RootW-1:0] rr_r [RootW+1];
  logic signed [CW-1:0] rax_r [RootW+1], ray_r [RootW+1];
  logic signed [AngW-1:0] raz_r [RootW+1];
  logic [29:0] rsz_r [RootW+1];
  logic rzn_r [RootW+1], rdg_r [RootW+1], rzp_r [RootW+1];

  always_comb begin
    rn_r[0]  = {2'b00, sq4_r};
    rr_r[0]  = '0;
    rax_r[0] = ax4_r; ray_r[0] = ay4_r; raz_r[0] = az4_r;
    rsz_r[0] = sz4_r; rzn_r[0] = zn4_r; rdg_r[0] = dg4_r; rzp_r[0] = zp4_r;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_root
    localparam int B = RootW - 1 - k;
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem;
    assign trial = ((SqW+2)'(rr_r[k]) << (B + 1)) | ((SqW+2)'(1) << (2 * B));
    assign rem   = rn_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem >= trial) begin
          rn_r[k+1] <= rem - trial;
          rr_r[k+1] <= rr_r[k] | (RootW'(1) << B);
        end else begin
          rn_r[k+1] <= rem;
          rr_r[k+1] <= rr_r[k];
        end
        rax_r[k+1] <= rax_r[k]; ray_r[k+1] <= ray_r[k]; raz_r[k+1] <= raz_r[k];
        rsz_r[k+1] <= rsz_r[k]; rzn_r[k+1] <= rzn_r[k];
        rdg_r[k+1] <= rdg_r[k]; rzp_r[k+1] <= rzp_r[k];
      end
    end
  end

  // dual CORDIC vectoring
  logic signed [CW-1:0] axc [CordicStages+1], ayc [CordicStages+1];
  logic signed [CW-1:0] exc [CordicStages+1], eyc [CordicStages+1];
  logic signed [AngW-1:0] azc [CordicStages+1], ezc [CordicStages+1];
  logic cdg [CordicStages+1], czn [CordicStages+1], czp [CordicStages+1];

  always_comb begin
    axc[0] = rax_r[RootW]; ayc[0] = ray_r[RootW]; azc[0] = raz_r[RootW];
    exc[0] = CW'(rr_r[RootW]);
    eyc[0] = rzn_r[RootW] ? -CW'(rsz_r[RootW]) : CW'(rsz_r[RootW]);
    ezc[0] = '0;
    cdg[0] = rdg_r[RootW]; czn[0] = rzn_r[RootW]; czp[0] = rzp_r[RootW];
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ayc[i][CW-1]) begin
          axc[i+1] <= axc[i] + (ayc[i] >>> i);
          ayc[i+1] <= ayc[i] - (axc[i] >>> i);
          azc[i+1] <= azc[i] + atan_deg(i);
        end else begin
          axc[i+1] <= axc[i] - (ayc[i] >>> i);
          ayc[i+1] <= ayc[i] + (axc[i] >>> i);
          azc[i+1] <= azc[i] - atan_deg(i);
        end
        if (!eyc[i][CW-1]) begin
          exc[i+1] <= exc[i] + (eyc[i] >>> i);
          eyc[i+1] <= eyc[i] - (exc[i] >>> i);
          ezc[i+1] <= ezc[i] + atan_deg(i);
        end else begin
          exc[i+1] <= exc[i] - (eyc[i] >>> i);
          eyc[i+1] <= eyc[i] + (exc[i] >>> i);
          ezc[i+1] <= ezc[i] - atan_deg(i);
        end
        cdg[i+1] <= cdg[i]; czn[i+1] <= czn[i]; czp[i+1] <= czp[i];
      end
    end
  end

  // output register
  logic signed [AngW-1:0] el_f, az_f;
  logic [ElevW-1:0] el_r;
  logic [AzimW-1:0] az_r;
  logic dg_r;
  localparam int L = CordicStages;
  always_comb begin
    if (cdg[L]) begin
      az_f = '0;
      el_f = czp[L] ? ElevLim : (czn[L] ? -ElevLim : '0);
    end else begin
      az_f = finish(azc[L], AzimLim);
      el_f = finish(ezc[L], ElevLim);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      el_r <= el_f[ElevW-1:0];
      az_r <= az_f[AzimW-1:0];
      dg_r <= cdg[L];
    end
  end

  assign out_tvalid = vld_r[NS];
  assign out_tdata  = {7'd0, az_r, el_r};
  assign out_tuser  = dg_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_degen_az: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[32:16] == '0)
    else $error("degenerate result with nonzero azimuth");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule
